/* rtl/core/vcnd_pkg.sv */
// Shared types and constants for the voxel corner node dedup core.
// No dependencies.
package vcnd_pkg;

  localparam int COORD_W  = 24;
  localparam int NODE_W   = 12;
  localparam int SLOT_W   = 3;
  localparam int CORNERS  = 8;

  typedef struct packed {
    logic                       new_mesh;
    logic signed [COORD_W-1:0]  min_x;
    logic signed [COORD_W-1:0]  min_y;
    logic signed [COORD_W-1:0]  min_z;
    logic signed [COORD_W-1:0]  max_x;
    logic signed [COORD_W-1:0]  max_y;
    logic signed [COORD_W-1:0]  max_z;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]          corner_slot;
    logic [NODE_W-1:0]          node_index;
    logic                       is_new;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  point_z;
    logic                       last_corner;
    logic                       table_full;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } state_t;

endpackage

/* rtl/core/vcnd_if.sv */
// Valid/ready channel interfaces for voxel requests and corner results.
// Depends on vcnd_pkg.
interface vcnd_in_if;
  logic              valid;
  logic              ready;
  vcnd_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vcnd_out_if;
  logic               valid;
  logic               ready;
  vcnd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/vcnd_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module vcnd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/voxel_corner_node_dedup_core.sv */
// Top level: voxel corner dedup against a linear-probed point table in RAM.
// Depends on vcnd_pkg, vcnd_if and vcnd_ram.
//
//  channel | dir | handshake          | payload
//  in_ch   | in  | valid/ready        | new_mesh, min_xyz, max_xyz
//  out_ch  | out | valid/ready        | corner_slot .. table_full, 8 per voxel
//
// Each probe is a RAM read state (ST_READ) followed by a compare state (ST_CMP).
// After reset and on every new_mesh request, a clearing pass writes each of the
// TABLE_ENTRIES slots once before any lookup.
// A stalled result holds in the output register; the lookup waits behind it.
module voxel_corner_node_dedup_core #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int COORD_BITS    = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  vcnd_in_if.sink    in_ch,
  vcnd_out_if.source out_ch
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int KW = (COORD_BITS < vcnd_pkg::COORD_W) ? COORD_BITS : vcnd_pkg::COORD_W;
  localparam int MW = 1 + AW + 3 * KW;
  localparam logic [AW:0]   ENT_N    = (AW+1)'(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_POS = AW'(TABLE_ENTRIES - 1);

  vcnd_pkg::state_t state_r, state_nxt;
  logic [KW-1:0]    mn_x_r, mn_y_r, mn_z_r, mx_x_r, mx_y_r, mx_z_r;
  logic [KW-1:0]    mn_x_nxt, mn_y_nxt, mn_z_nxt, mx_x_nxt, mx_y_nxt, mx_z_nxt;
  logic [2:0]       corner_r, corner_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [AW-1:0]    probe_r, probe_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [AW:0]      next_node_r, next_node_nxt;
  logic             first_r, first_nxt;
  logic             pend_r, pend_nxt;
  vcnd_pkg::out_item_t res_r, res_nxt, out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  // current corner point
  logic          hx, hy, hz;
  logic [KW-1:0] px, py, pz, hs;
  logic [31:0]   h32;
  logic [AW-1:0] hraw, hash_pos, rd_addr, pos_inc;

  // RAM
  logic          we, re;
  logic [AW-1:0] waddr;
  logic [MW-1:0] wdata, rdata;
  logic          r_used, hit, done, is_new;
  logic [AW-1:0] r_node, idx;
  logic [KW-1:0] r_x, r_y, r_z;
  logic          out_free;
  vcnd_pkg::out_item_t res;

  assign hx = corner_r[0] ^ corner_r[1];
  assign hy = corner_r[1];
  assign hz = corner_r[2];
  assign px = hx ? mx_x_r : mn_x_r;
  assign py = hy ? mx_y_r : mn_y_r;
  assign pz = hz ? mx_z_r : mn_z_r;

  // any hash works; results do not depend on slot placement
  assign hs       = px ^ py ^ pz;
  assign h32      = 32'(hs) ^ (32'(hs) >> AW) ^ (32'(hs) >> (2 * AW));
  assign hraw     = h32[AW-1:0];
  assign hash_pos = ((AW+1)'(hraw) >= ENT_N) ? AW'((AW+1)'(hraw) - ENT_N) : hraw;
  assign rd_addr  = first_r ? hash_pos : pos_r;
  assign pos_inc  = (pos_r == LAST_POS) ? '0 : pos_r + AW'(1);

  assign {r_used, r_node, r_z, r_y, r_x} = rdata;
  assign hit      = r_used && (r_x == px) && (r_y == py) && (r_z == pz);
  assign done     = !r_used || hit || (probe_r == LAST_POS);
  assign is_new   = !r_used && (next_node_r < ENT_N);
  assign idx      = hit ? r_node : (is_new ? next_node_r[AW-1:0] : LAST_POS);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    res.corner_slot = corner_r;
    res.node_index  = vcnd_pkg::NODE_W'(idx);
    res.is_new      = is_new;
    res.point_x     = vcnd_pkg::COORD_W'(signed'(px));
    res.point_y     = vcnd_pkg::COORD_W'(signed'(py));
    res.point_z     = vcnd_pkg::COORD_W'(signed'(pz));
    res.last_corner = (corner_r == 3'(vcnd_pkg::CORNERS - 1));
    res.table_full  = !hit && !is_new;
  end

  vcnd_ram #(.WIDTH(MW), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign in_ch.ready  = (state_r == vcnd_pkg::ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    mn_x_nxt      = mn_x_r;
    mn_y_nxt      = mn_y_r;
    mn_z_nxt      = mn_z_r;
    mx_x_nxt      = mx_x_r;
    mx_y_nxt      = mx_y_r;
    mx_z_nxt      = mx_z_r;
    corner_nxt    = corner_r;
    pos_nxt       = pos_r;
    probe_nxt     = probe_r;
    clr_nxt       = clr_r;
    next_node_nxt = next_node_r;
    first_nxt     = first_r;
    pend_nxt      = pend_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = pos_r;
    wdata         = {1'b1, next_node_r[AW-1:0], pz, py, px};

    case (state_r)
      vcnd_pkg::ST_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_POS) begin
          state_nxt = pend_r ? vcnd_pkg::ST_READ : vcnd_pkg::ST_IDLE;
          pend_nxt  = 1'b0;
        end
      end
      vcnd_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          mn_x_nxt   = KW'(in_ch.data.min_x);
          mn_y_nxt   = KW'(in_ch.data.min_y);
          mn_z_nxt   = KW'(in_ch.data.min_z);
          mx_x_nxt   = KW'(in_ch.data.max_x);
          mx_y_nxt   = KW'(in_ch.data.max_y);
          mx_z_nxt   = KW'(in_ch.data.max_z);
          corner_nxt = '0;
          first_nxt  = 1'b1;
          probe_nxt  = '0;
          if (in_ch.data.new_mesh) begin
            clr_nxt       = '0;
            next_node_nxt = '0;
            pend_nxt      = 1'b1;
            state_nxt     = vcnd_pkg::ST_CLEAR;
          end else begin
            state_nxt = vcnd_pkg::ST_READ;
          end
        end
      end
      vcnd_pkg::ST_READ: begin
        re        = 1'b1;
        pos_nxt   = rd_addr;
        first_nxt = 1'b0;
        state_nxt = vcnd_pkg::ST_CMP;
      end
      vcnd_pkg::ST_CMP: begin
        if (!done) begin
          pos_nxt   = pos_inc;
          probe_nxt = probe_r + AW'(1);
          state_nxt = vcnd_pkg::ST_READ;
        end else begin
          if (is_new) begin
            we            = 1'b1;
            next_node_nxt = next_node_r + (AW+1)'(1);
          end
          if (out_free) begin
            out_nxt       = res;
            out_valid_nxt = 1'b1;
            first_nxt     = 1'b1;
            probe_nxt     = '0;
            corner_nxt    = corner_r + 3'd1;
            state_nxt     = res.last_corner ? vcnd_pkg::ST_IDLE : vcnd_pkg::ST_READ;
          end else begin
            res_nxt   = res;
            state_nxt = vcnd_pkg::ST_EMIT;
          end
        end
      end
      vcnd_pkg::ST_EMIT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          first_nxt     = 1'b1;
          probe_nxt     = '0;
          corner_nxt    = corner_r + 3'd1;
          state_nxt     = res_r.last_corner ? vcnd_pkg::ST_IDLE : vcnd_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = vcnd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vcnd_pkg::ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      next_node_r <= '0;
      out_valid_r <= 1'b0;
      corner_r    <= '0;
      first_r     <= 1'b1;
      probe_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      next_node_r <= next_node_nxt;
      out_valid_r <= out_valid_nxt;
      corner_r    <= corner_nxt;
      first_r     <= first_nxt;
      probe_r     <= probe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mn_x_r <= mn_x_nxt;
    mn_y_r <= mn_y_nxt;
    mn_z_r <= mn_z_nxt;
    mx_x_r <= mx_x_nxt;
    mx_y_r <= mx_y_nxt;
    mx_z_r <= mx_z_nxt;
    pos_r  <= pos_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

endmodule
